FILE: design/hjd_pkg.sv
// ----------------------------------------------------------------------------
// hjd_pkg
// Shared types, constants and helpers for the Hangul jamo decomposer.
// ----------------------------------------------------------------------------
package hjd_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;   // gathered codepoint bits
    localparam int SIDX_W = 14;   // syllable index, 0..11171
    localparam int Q_W    = 9;    // syllable index / 28, 0..398
    localparam int T_W    = 5;    // trailing / vowel / leading jamo index
    localparam int BUF_W  = 72;   // up to nine result bytes

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEAD = 2'd1;
    localparam logic [1:0] STATUS_TRUNC    = 2'd2;

    // Hangul syllable block and jamo bases
    localparam logic [CP_W-1:0] SYL_FIRST  = 21'h00AC00;
    localparam logic [CP_W-1:0] SYL_LAST   = 21'h00D7A3;
    localparam logic [15:0]     LEAD_BASE  = 16'h1100;
    localparam logic [15:0]     VOWEL_BASE = 16'h1161;
    localparam logic [15:0]     TRAIL_BASE = 16'h11A7;

    // Reciprocals: x/7 = (x*2341)>>14 for x < 4096, q/21 = (q*3121)>>16 for q < 512
    localparam logic [11:0] DIV7_RECIP  = 12'd2341;
    localparam int          DIV7_SHIFT  = 14;
    localparam logic [11:0] DIV21_RECIP = 12'd3121;
    localparam int          DIV21_SHIFT = 16;

    // What a decoded input byte turns into
    typedef enum logic [1:0] {
        KIND_RAW,   // pass-through bytes
        KIND_SYL,   // Hangul syllable, to be split into jamo
        KIND_ERR    // single error beat
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [31:0]       bytes;    // first byte in bits 7..0
        logic [2:0]        cnt;      // number of pass-through bytes
        logic [SIDX_W-1:0] syl_idx;  // codepoint - 0xAC00
        logic [Q_W-1:0]    quot;     // syl_idx / 28
        logic [T_W-1:0]    trail;    // syl_idx % 28
        logic [1:0]        status;
        logic              eot;      // item closes the text
    } hjd_item_t;

    // 3-byte UTF-8 encoding of a BMP codepoint, first byte in bits 7..0
    function automatic logic [23:0] jamo_utf8(input logic [15:0] cp);
        return {2'b10, cp[5:0], 2'b10, cp[11:6], 4'hE, cp[15:12]};
    endfunction

endpackage

FILE: design/hjd_parse.sv
// ----------------------------------------------------------------------------
// hjd_parse
// UTF-8 sequence gatherer. Tracks the open sequence and the error halt,
// and registers one decoded item per input byte that produces results.
// ----------------------------------------------------------------------------
module hjd_parse import hjd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_in_byte,
    input  logic              s_end_of_text,
    output logic              rec_valid,
    output hjd_item_t         rec,
    input  logic              rec_ready
);

    logic [CP_W-1:0] partial_reg, partial_next;
    logic [23:0]     held_reg, held_next;
    logic [2:0]      seq_len_reg, seq_len_next;
    logic [1:0]      need_reg, need_next;
    logic            halted_reg, halted_next;
    logic            rec_valid_reg;
    hjd_item_t       rec_reg;

    logic            accept;
    logic            emit;
    hjd_item_t       item;
    logic [1:0]      idx;
    logic [1:0]      need_dec;
    logic [CP_W-1:0] cp_new;
    logic [CP_W-1:0] syl_off;
    logic [31:0]     placed;
    logic            b_lead2, b_lead3, b_lead4;

    assign s_ready = !rec_valid_reg || rec_ready;
    assign accept  = s_valid && s_ready;

    assign b_lead2 = (s_in_byte[7:5] == 3'b110);
    assign b_lead3 = (s_in_byte[7:4] == 4'b1110);
    assign b_lead4 = (s_in_byte[7:3] == 5'b11110);

    // continuation helpers
    assign idx      = seq_len_reg[1:0] - need_reg;
    assign need_dec = need_reg - 2'd1;
    assign cp_new   = {partial_reg[CP_W-7:0], s_in_byte[5:0]};
    assign syl_off  = cp_new - SYL_FIRST;
    assign placed   = {24'b0, s_in_byte} << {idx, 3'b000};

    // sequence state and decoded item
    always_comb begin
        partial_next = partial_reg;
        held_next    = held_reg;
        seq_len_next = seq_len_reg;
        need_next    = need_reg;
        halted_next  = halted_reg;
        emit         = 1'b0;
        item         = '0;
        item.kind    = KIND_RAW;
        item.status  = STATUS_OK;
        item.eot     = s_end_of_text;

        if (accept) begin
            if (halted_reg) begin
                // drop bytes until end of text
            end else if (need_reg == 2'd0) begin
                if (!s_in_byte[7]) begin
                    emit       = 1'b1;
                    item.bytes = {24'b0, s_in_byte};
                    item.cnt   = 3'd1;
                end else if (b_lead2 || b_lead3 || b_lead4) begin
                    held_next = {16'b0, s_in_byte};
                    if (b_lead2) begin
                        partial_next = {16'b0, s_in_byte[4:0]};
                        seq_len_next = 3'd2;
                        need_next    = 2'd1;
                    end else if (b_lead3) begin
                        partial_next = {17'b0, s_in_byte[3:0]};
                        seq_len_next = 3'd3;
                        need_next    = 2'd2;
                    end else begin
                        partial_next = {18'b0, s_in_byte[2:0]};
                        seq_len_next = 3'd4;
                        need_next    = 2'd3;
                    end
                    if (s_end_of_text) begin
                        emit        = 1'b1;
                        item.kind   = KIND_ERR;
                        item.status = STATUS_TRUNC;
                    end
                end else begin
                    emit        = 1'b1;
                    item.kind   = KIND_ERR;
                    item.status = STATUS_BAD_LEAD;
                end
            end else begin
                need_next = need_dec;
                if (need_dec != 2'd0) begin
                    partial_next = cp_new;
                    held_next    = held_reg | placed[23:0];
                    if (s_end_of_text) begin
                        emit        = 1'b1;
                        item.kind   = KIND_ERR;
                        item.status = STATUS_TRUNC;
                    end
                end else begin
                    emit = 1'b1;
                    if (cp_new >= SYL_FIRST && cp_new <= SYL_LAST) begin
                        item.kind    = KIND_SYL;
                        item.syl_idx = syl_off[SIDX_W-1:0];
                    end else begin
                        item.bytes = {8'b0, held_reg} | placed;
                        item.cnt   = seq_len_reg;
                    end
                    partial_next = '0;
                    held_next    = '0;
                    seq_len_next = '0;
                end
            end

            // errors and end of text both clear the sequence state
            if (emit && (item.kind == KIND_ERR || s_end_of_text)) begin
                partial_next = '0;
                held_next    = '0;
                seq_len_next = '0;
                need_next    = '0;
                halted_next  = (item.kind == KIND_ERR) && !s_end_of_text;
            end else if (s_end_of_text) begin
                partial_next = '0;
                held_next    = '0;
                seq_len_next = '0;
                need_next    = '0;
                halted_next  = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            held_reg    <= '0;
            seq_len_reg <= '0;
            need_reg    <= '0;
            halted_reg  <= 1'b0;
        end else begin
            partial_reg <= partial_next;
            held_reg    <= held_next;
            seq_len_reg <= seq_len_next;
            need_reg    <= need_next;
            halted_reg  <= halted_next;
        end
    end

    // decoded item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_valid_reg <= 1'b0;
        end else if (s_ready) begin
            rec_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            rec_reg <= item;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule

FILE: design/hjd_divide.sv
// ----------------------------------------------------------------------------
// hjd_divide
// Splits the syllable index by 28: quotient by reciprocal multiply,
// remainder (trailing jamo index) by shift-and-add back-multiply.
// ----------------------------------------------------------------------------
module hjd_divide import hjd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  hjd_item_t in_item,
    output logic      out_valid,
    output hjd_item_t out_item,
    input  logic      out_ready
);

    logic            valid_reg;
    hjd_item_t       item_reg;
    hjd_item_t       item_next;
    logic [23:0]     prod;
    logic [Q_W-1:0]  quot;
    logic [SIDX_W-1:0] quot28;
    logic [SIDX_W-1:0] rem;

    assign in_ready = !valid_reg || out_ready;

    // idx/28 = (idx>>2)/7
    assign prod   = {12'b0, in_item.syl_idx[SIDX_W-1:2]} * {12'b0, DIV7_RECIP};
    assign quot   = prod[DIV7_SHIFT +: Q_W];
    assign quot28 = ({5'b0, quot} << 4) + ({5'b0, quot} << 3) + ({5'b0, quot} << 2);
    assign rem    = in_item.syl_idx - quot28;

    always_comb begin
        item_next       = in_item;
        item_next.quot  = quot;
        item_next.trail = rem[T_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: design/hjd_burst.sv
// ----------------------------------------------------------------------------
// hjd_burst
// Result burst buffer. Formats an item into up to nine bytes (jamo,
// pass-through or error) and shifts them out one beat per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module hjd_burst import hjd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  hjd_item_t         in_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic [1:0]        m_status,
    output logic              m_run_last,
    output logic              m_text_last
);

    logic [BUF_W-1:0] buf_reg, buf_next;
    logic [3:0]       rem_reg, rem_next;
    logic [1:0]       status_reg, status_next;
    logic             eot_reg, eot_next;

    logic             load;
    logic             beat;
    logic [20:0]      prod;
    logic [T_W-1:0]   lead_idx;
    logic [Q_W-1:0]   lead21;
    logic [Q_W-1:0]   vowel_full;
    logic [15:0]      lead_cp, vowel_cp, trail_cp;
    logic [BUF_W-1:0] load_buf;
    logic [3:0]       load_cnt;

    assign beat     = m_valid && m_ready;
    assign in_ready = (rem_reg == 4'd0) || (rem_reg == 4'd1 && m_ready);
    assign load     = in_valid && in_ready;

    // leading = quot/21, vowel = quot%21
    assign prod       = {12'b0, in_item.quot} * {9'b0, DIV21_RECIP};
    assign lead_idx   = prod[DIV21_SHIFT +: T_W];
    assign lead21     = ({4'b0, lead_idx} << 4) + ({4'b0, lead_idx} << 2) + {4'b0, lead_idx};
    assign vowel_full = in_item.quot - lead21;

    assign lead_cp  = LEAD_BASE + {11'b0, lead_idx};
    assign vowel_cp = VOWEL_BASE + {11'b0, vowel_full[T_W-1:0]};
    assign trail_cp = TRAIL_BASE + {11'b0, in_item.trail};

    // burst contents for a new item
    always_comb begin
        load_buf = '0;
        load_cnt = 4'd1;
        unique case (in_item.kind)
            KIND_SYL: begin
                load_buf = {jamo_utf8(trail_cp), jamo_utf8(vowel_cp), jamo_utf8(lead_cp)};
                load_cnt = (in_item.trail != '0) ? 4'd9 : 4'd6;
            end
            KIND_RAW: begin
                load_buf = {40'b0, in_item.bytes};
                load_cnt = {1'b0, in_item.cnt};
            end
            default: begin
                load_buf = '0;
                load_cnt = 4'd1;
            end
        endcase
    end

    // load or shift the burst buffer
    always_comb begin
        buf_next    = buf_reg;
        rem_next    = rem_reg;
        status_next = status_reg;
        eot_next    = eot_reg;
        if (load) begin
            buf_next    = load_buf;
            rem_next    = load_cnt;
            status_next = in_item.status;
            eot_next    = in_item.eot || (in_item.kind == KIND_ERR);
        end else if (beat) begin
            buf_next = {8'b0, buf_reg[BUF_W-1:BYTE_W]};
            rem_next = rem_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg    <= buf_next;
        status_reg <= status_next;
        eot_reg    <= eot_next;
    end

    assign m_valid     = (rem_reg != 4'd0);
    assign m_out_byte  = buf_reg[BYTE_W-1:0];
    assign m_status    = status_reg;
    assign m_run_last  = (rem_reg == 4'd1);
    assign m_text_last = (rem_reg == 4'd1) && eot_reg;

endmodule

FILE: design/utf8_hangul_jamo_decomposer.sv
// The first result beat of a byte is offered once it has passed the item, divide and
// burst registers, in that order; back-pressure can stall each of them.
// Throughput: one result beat per cycle while m_ready is high, from the single-beat
// output shifter (6 or 9 beats for a syllable's last byte), which loads the next item.
// Bytes that produce no result are taken one per cycle unless the item register stalls.
// Reset: synchronous, active low; clears the sequence state, halt and all valids.
// ----------------------------------------------------------------------------
// utf8_hangul_jamo_decomposer
// Streaming UTF-8 Hangul syllable to jamo decomposer: gather, divide, burst.
// ----------------------------------------------------------------------------
module utf8_hangul_jamo_decomposer import hjd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_in_byte,
    input  logic              s_end_of_text,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic [1:0]        m_status,
    output logic              m_run_last,
    output logic              m_text_last
);

    logic      rec_valid, rec_ready;
    hjd_item_t rec;
    logic      div_valid, div_ready;
    hjd_item_t div_item;

    hjd_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .rec_valid     (rec_valid),
        .rec           (rec),
        .rec_ready     (rec_ready)
    );

    hjd_divide u_divide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rec_valid),
        .in_ready  (rec_ready),
        .in_item   (rec),
        .out_valid (div_valid),
        .out_item  (div_item),
        .out_ready (div_ready)
    );

    hjd_burst u_burst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (div_valid),
        .in_ready    (div_ready),
        .in_item     (div_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_status    (m_status),
        .m_run_last  (m_run_last),
        .m_text_last (m_text_last)
    );

    // error beats are single, zero and close the text
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_run_last && m_text_last && m_out_byte == 8'd0)
        else $error("error beat not a lone closing zero beat");

    // end of text only on the last beat of a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_text_last |-> m_run_last)
        else $error("text_last without run_last");

    // a burst continues without gaps until its last beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> m_valid)
        else $error("burst broken before its last beat");

endmodule
